// File: src/spmv_pkg.sv
// Shared types and constants for the packed low-precision sparse row engine.
`default_nettype none

package spmv_pkg;

  // Fixed payload widths.
  localparam int CMD_W    = 2;
  localparam int WIDX_W   = 8;
  localparam int WORD_W   = 32;
  localparam int VALUE_W  = 8;
  localparam int COL_W    = 10;
  localparam int OUT_W    = 32;
  localparam int MODE_W   = 2;
  localparam int BYTES_W  = WORD_W / VALUE_W;   // elements per vector word
  localparam int BSEL_W   = $clog2(BYTES_W);

  // Signed width that holds the sum of the lane products.
  localparam int DOT_W    = 10;

  // Default values for the top-level parameters.
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int SUM_BITS_DEF    = 32;

  // Depth of the queue between the front and back parts.
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // Command codes of an input transaction.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_NONZERO = 2'd1,
    CMD_EMPTY   = 2'd2
  } cmd_t;

  // Precision mode codes; any other code selects two 4-bit lanes.
  localparam logic [MODE_W-1:0] MODE_INT8 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INT2 = 2'd1;

  // One classified operation as it sits in the queue.
  typedef struct packed {
    cmd_t                kind;
    logic [WIDX_W-1:0]   addr;   // vector word address (load or read)
    logic [WORD_W-1:0]   word;
    logic [VALUE_W-1:0]  mval;
    logic [BSEL_W-1:0]   bsel;   // element within the word
    logic                hit;    // address lies inside the vector store
    logic                last;
  } op_t;

endpackage

`default_nettype wire

// File: src/spmv_if.sv
// Handshake channel interfaces: input items, results and configuration writes.
`default_nettype none

interface spmv_in_if;
  logic                              valid;
  logic                              ready;
  logic [spmv_pkg::CMD_W-1:0]        command;
  logic [spmv_pkg::WIDX_W-1:0]       vector_word_index;
  logic [spmv_pkg::WORD_W-1:0]       vector_word;
  logic [spmv_pkg::VALUE_W-1:0]      matrix_value;
  logic [spmv_pkg::COL_W-1:0]        column;
  logic                              row_end;

  modport source (output valid, command, vector_word_index, vector_word, matrix_value,
                  column, row_end, input ready);
  modport sink   (input valid, command, vector_word_index, vector_word, matrix_value,
                  column, row_end, output ready);
endinterface

interface spmv_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [spmv_pkg::OUT_W-1:0] row_sum;

  modport source (output valid, row_sum, input ready);
  modport sink   (input valid, row_sum, output ready);
endinterface

interface spmv_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [spmv_pkg::MODE_W-1:0]       precision_mode;

  modport source (output valid, precision_mode, input ready);
  modport sink   (input valid, precision_mode, output ready);
endinterface

`default_nettype wire

// File: src/spmv_front.sv
// Front part: accepts input transactions, classifies them and queues them.
`default_nettype none

module spmv_front #(
  parameter int MAX_COLUMNS = spmv_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  spmv_in_if.sink           items,
  output spmv_pkg::op_t     head,
  output logic              head_valid,
  input  wire logic         pop
);

  localparam int WORDS = (MAX_COLUMNS + spmv_pkg::BYTES_W - 1) / spmv_pkg::BYTES_W;

  spmv_pkg::op_t                  queue [spmv_pkg::QDEPTH];
  logic [spmv_pkg::QPTR_W-1:0]    wr_ptr;
  logic [spmv_pkg::QPTR_W-1:0]    rd_ptr;
  logic [spmv_pkg::QCNT_W-1:0]    count;
  spmv_pkg::op_t                  op;
  logic                           keep;
  logic                           push;
  logic                           do_pop;

  // Classify the incoming item. The unused command code is taken and dropped.
  always_comb begin
    op      = '0;
    keep    = 1'b0;
    op.word = items.vector_word;
    op.mval = items.matrix_value;
    op.last = items.row_end;
    case (items.command)
      spmv_pkg::CMD_LOAD: begin
        keep    = 1'b1;
        op.kind = spmv_pkg::CMD_LOAD;
        op.addr = items.vector_word_index;
        op.hit  = 32'(items.vector_word_index) < 32'(WORDS);
      end
      spmv_pkg::CMD_NONZERO: begin
        keep    = 1'b1;
        op.kind = spmv_pkg::CMD_NONZERO;
        op.addr = items.column[spmv_pkg::COL_W-1:spmv_pkg::BSEL_W];
        op.bsel = items.column[spmv_pkg::BSEL_W-1:0];
        op.hit  = 32'(items.column) < 32'(MAX_COLUMNS);
      end
      spmv_pkg::CMD_EMPTY: begin
        keep    = 1'b1;
        op.kind = spmv_pkg::CMD_EMPTY;
      end
      default: begin
        keep    = 1'b0;
      end
    endcase
  end

  assign items.ready = (count != spmv_pkg::QCNT_W'(spmv_pkg::QDEPTH));
  assign push        = items.valid && items.ready && keep;
  assign head_valid  = (count != '0);
  assign do_pop      = pop && head_valid;
  assign head        = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= op;
    end
  end

endmodule

`default_nettype wire

// File: src/spmv_back.sv
// Back part: vector store, lane multiplies, row accumulator and result register.
`default_nettype none

module spmv_back #(
  parameter int MAX_COLUMNS = spmv_pkg::MAX_COLUMNS_DEF,
  parameter int SUM_BITS    = spmv_pkg::SUM_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [spmv_pkg::MODE_W-1:0]  precision_mode,
  input  wire spmv_pkg::op_t                head,
  input  wire logic                         head_valid,
  output logic                              pop,
  spmv_out_if.source                        results
);

  localparam int WORDS = (MAX_COLUMNS + spmv_pkg::BYTES_W - 1) / spmv_pkg::BYTES_W;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [spmv_pkg::WORD_W-1:0]   mem [WORDS];
  logic [spmv_pkg::WORD_W-1:0]   rd_data;
  logic [WA_W-1:0]               mem_addr;
  logic                          advance;

  // Stage A: memory data is available.
  logic                          va;
  spmv_pkg::cmd_t                a_kind;
  logic [spmv_pkg::VALUE_W-1:0]  a_mval;
  logic [spmv_pkg::BSEL_W-1:0]   a_bsel;
  logic                          a_hit;
  logic                          a_last;
  logic [spmv_pkg::VALUE_W-1:0]  elem;
  logic signed [spmv_pkg::DOT_W-1:0] dot;

  // Stage B: lane product sum is available.
  logic                          vb;
  spmv_pkg::cmd_t                b_kind;
  logic                          b_last;
  logic signed [spmv_pkg::DOT_W-1:0] b_dot;

  // Accumulate and result stage.
  logic signed [SUM_BITS-1:0]    acc;
  logic signed [SUM_BITS-1:0]    acc_sum;
  logic                          out_valid;
  logic signed [spmv_pkg::OUT_W-1:0] row_sum;

  assign advance  = !out_valid || results.ready;
  assign pop      = advance && head_valid;
  assign mem_addr = WA_W'(head.addr);

  always_ff @(posedge clk) begin
    if (pop && head.kind == spmv_pkg::CMD_LOAD && head.hit) begin
      mem[mem_addr] <= head.word;
    end
    if (advance) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (advance) begin
      va <= pop;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_kind <= head.kind;
      a_mval <= head.mval;
      a_bsel <= head.bsel;
      a_hit  <= head.hit;
      a_last <= head.last;
      b_kind <= a_kind;
      b_last <= a_last;
      b_dot  <= dot;
    end
  end

  // Lane products, each kept at its lane width, then summed.
  always_comb begin
    logic [7:0]  m8;
    logic [1:0]  m2;
    logic [3:0]  m4;
    logic signed [spmv_pkg::DOT_W-1:0] s2;
    logic signed [spmv_pkg::DOT_W-1:0] s4;
    elem = a_hit ? rd_data[spmv_pkg::VALUE_W*a_bsel +: spmv_pkg::VALUE_W] : '0;
    m8   = a_mval * elem;
    s2   = '0;
    for (int z = 0; z < 4; z++) begin
      m2 = a_mval[2*z +: 2] * elem[2*z +: 2];
      s2 = s2 + spmv_pkg::DOT_W'(signed'(m2));
    end
    s4 = '0;
    for (int z = 0; z < 2; z++) begin
      m4 = a_mval[4*z +: 4] * elem[4*z +: 4];
      s4 = s4 + spmv_pkg::DOT_W'(signed'(m4));
    end
    case (precision_mode)
      spmv_pkg::MODE_INT8: dot = spmv_pkg::DOT_W'(signed'(m8));
      spmv_pkg::MODE_INT2: dot = s2;
      default:             dot = s4;
    endcase
  end

  assign acc_sum = acc + SUM_BITS'(b_dot);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vb && (b_kind == spmv_pkg::CMD_EMPTY ||
                          (b_kind == spmv_pkg::CMD_NONZERO && b_last));
      if (vb && b_kind == spmv_pkg::CMD_NONZERO) begin
        acc <= b_last ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && vb) begin
      if (b_kind == spmv_pkg::CMD_NONZERO) begin
        row_sum <= spmv_pkg::OUT_W'(acc_sum);
      end else if (b_kind == spmv_pkg::CMD_EMPTY) begin
        row_sum <= '0;
      end
    end
  end

  assign results.valid   = out_valid;
  assign results.row_sum = row_sum;

endmodule

`default_nettype wire

// File: src/packed_low_precision_spmv_row_engine.sv
// Top level of the packed low-precision CSR sparse row engine.
`default_nettype none

// The engine takes one input transaction per clock cycle while its queue has room
// and returns at most one row sum per transaction, in order. A front part
// classifies each transaction (vector load, nonzero, empty row, or the unused
// code, which is dropped) and places it in a four-entry queue. A back part pops
// one operation per cycle unless the result register is held: a load writes one
// 32-bit word into the vector store, a nonzero reads the word that holds its
// column, multiplies the packed lanes in the next cycle and adds the truncated
// lane products, registered in stage B, to the row accumulator. The result
// register then holds the row sum until the consumer takes it. Sustained rate is
// one transaction per cycle while results are taken, set by the single write and
// single read port of the vector store, both used at most once per cycle. While
// the result register is held, the back part pauses and the queue keeps absorbing
// up to four transactions. The vector store has no reset; a nonzero must only
// read elements loaded since reset. The precision mode is written on its own
// channel, which is always ready, and must only change while the engine is idle.
module packed_low_precision_spmv_row_engine #(
  parameter int MAX_COLUMNS = spmv_pkg::MAX_COLUMNS_DEF,
  parameter int SUM_BITS    = spmv_pkg::SUM_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  spmv_cfg_if.sink    cfg,
  spmv_in_if.sink     items,
  spmv_out_if.source  results
);

  logic [spmv_pkg::MODE_W-1:0] precision_mode;
  spmv_pkg::op_t               head;
  logic                        head_valid;
  logic                        pop;

  // Configuration register: taken in every cycle the write channel is valid.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      precision_mode <= spmv_pkg::MODE_INT8;
    end else if (cfg.valid) begin
      precision_mode <= cfg.precision_mode;
    end
  end

  spmv_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  spmv_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .SUM_BITS    (SUM_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .precision_mode (precision_mode),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .results        (results)
  );

endmodule

`default_nettype wire
